@@ hdl/plist_pkg.sv @@
// Package for the positional list engine.
// Holds the list capacity, the command codes and the transaction and cell control structs.
// No dependencies.
`default_nettype none

package plist_pkg;

  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 7;

  // The position and length fields are sized for this capacity.
  localparam int unsigned CAPACITY = 64;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_RETRIEVE = 2'd2
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t                    cmd;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  new_value;
  } in_t;

  typedef struct packed {
    logic                      ok;
    logic signed [DATA_W-1:0]  read_value;
    logic [LEN_W-1:0]          length;
  } out_t;

  // Broadcast to every cell in the row for one accepted command.
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic [POS_W-1:0]          pos;
    logic [DATA_W-1:0]         value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/positional_list_engine.sv @@
// Positional list engine: ordered list held in a row of shifting cells.
// The result strobes on out_valid in the cycle after start is taken.
// Throughput: one command per cycle; busy stays low, since every cell shifts
// in the same cycle the command is accepted.
// Reset: synchronous, active low; clears the length and the result strobe only.
// Depends on plist_pkg and plist_cell.
`default_nettype none

module positional_list_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire plist_pkg::in_t    in_item,
  output logic                   out_valid,
  output plist_pkg::out_t        out_item
);

  localparam int unsigned CAPACITY = plist_pkg::CAPACITY;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]                  count_r;
  logic [CW-1:0]                  count_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  plist_pkg::out_t                out_item_r;
  plist_pkg::out_t                out_item_nxt;
  plist_pkg::cell_ctrl_t          ctrl;
  logic [31:0]                    cnt32;
  logic [31:0]                    pos32;
  logic                           accept;
  logic                           ins_ok;
  logic                           rem_ok;
  logic                           ret_ok;
  logic [plist_pkg::DATA_W-1:0]   cell_data [CAPACITY];
  logic [plist_pkg::DATA_W-1:0]   cell_hit  [CAPACITY];
  logic [plist_pkg::DATA_W-1:0]   rd_any;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cnt32  = 32'(count_r);
  assign pos32  = 32'(in_item.position);

  always_comb begin
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    ret_ok = 1'b0;
    case (in_item.cmd)
      plist_pkg::CMD_INSERT:   ins_ok = (pos32 <= cnt32) && (cnt32 < CAPACITY);
      plist_pkg::CMD_REMOVE:   rem_ok = pos32 < cnt32;
      plist_pkg::CMD_RETRIEVE: ret_ok = (pos32 >= 32'd1) && (pos32 <= cnt32);
      default: ;
    endcase
  end

  assign ctrl.ins   = accept && ins_ok;
  assign ctrl.rem   = accept && rem_ok;
  assign ctrl.pos   = in_item.position;
  assign ctrl.value = in_item.new_value;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      plist_cell #(
        .IDX (g)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .left_data  ((g == 0) ? in_item.new_value : cell_data[(g == 0) ? 0 : g - 1]),
        .right_data ((g == CAPACITY - 1) ? cell_data[g]
                                         : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
        .data       (cell_data[g]),
        .hit_data   (cell_hit[g])
      );
    end
  endgenerate

  // At most one cell matches a retrieve position, so an OR merges them.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_hit[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt           = accept;
    out_item_nxt.ok         = ins_ok || rem_ok || ret_ok;
    out_item_nxt.length     = plist_pkg::LEN_W'(count_nxt);
    out_item_nxt.read_value = '0;
    if (in_item.cmd == plist_pkg::CMD_RETRIEVE) begin
      out_item_nxt.read_value = ret_ok ? rd_any : '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt32 <= CAPACITY)
    else $error("list length exceeds capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_fail_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.ok) |-> (count_r == $past(count_r)))
    else $error("failed transaction changed the length");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.ok && ($past(in_item.cmd) == plist_pkg::CMD_INSERT))
      |-> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("successful insert did not grow the list by one");

  a_retrieve_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.ok && ($past(in_item.cmd) == plist_pkg::CMD_RETRIEVE))
      |-> (out_item.read_value == '1))
    else $error("failed retrieve did not read back minus one");

endmodule

`default_nettype wire

@@ hdl/plist_cell.sv @@
// One storage cell of the list row.
// Depends on plist_pkg for the cell control struct.
`default_nettype none

module plist_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                              clk,
  input  wire plist_pkg::cell_ctrl_t             ctrl,
  input  wire logic [plist_pkg::DATA_W-1:0]      left_data,
  input  wire logic [plist_pkg::DATA_W-1:0]      right_data,
  output logic      [plist_pkg::DATA_W-1:0]      data,
  output logic      [plist_pkg::DATA_W-1:0]      hit_data
);

  logic [plist_pkg::DATA_W-1:0] data_r;
  logic [plist_pkg::DATA_W-1:0] data_nxt;
  logic [31:0]                  pos32;

  assign pos32 = 32'(ctrl.pos);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (IDX > pos32) begin
        data_nxt = left_data;
      end else if (IDX == pos32) begin
        data_nxt = ctrl.value;
      end
    end else if (ctrl.rem) begin
      if (IDX >= pos32) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  // Retrieve positions are one-based; only the matching cell drives a value.
  assign hit_data = ((IDX + 1) == pos32) ? data_r : '0;

endmodule

`default_nettype wire
